// ===== hdl/fms_pkg.sv =====
package fms_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_RESET = 2'd2,
    REQ_POP   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HOME   = 3'd1,
    PH_GRIP   = 3'd2,
    PH_ROTATE = 3'd3,
    PH_SETTLE = 3'd4,
    PH_DONE   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_HOME = 2'd1,
    TGT_HALF = 2'd2
  } target_e;

  typedef enum logic [1:0] {
    VLV_NONE    = 2'd0,
    VLV_HOLD    = 2'd1,
    VLV_RELEASE = 2'd2
  } valve_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_HOME     = 2'd1,
    EV_ROTATE   = 2'd2,
    EV_FINISHED = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    CFG_GRIP_DELAY   = 2'd0,
    CFG_SETTLE_DELAY = 2'd1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned TimeW   = 32;

  localparam logic [DelayW-1:0] GripDelayRst   = 16'd250;
  localparam logic [DelayW-1:0] SettleDelayRst = 16'd200;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [TimeW-1:0] now_ms;
    logic             raw_arrived;
  } in_item_t;

  typedef struct packed {
    logic [1:0] target_cmd;
    logic       motor_stop;
    logic [1:0] valve_cmd;
    logic [2:0] phase_now;
    logic [1:0] popped_event;
    logic       is_done;
  } out_item_t;

  typedef struct packed {
    logic valid;
  } stage_hs_t;

endpackage

// ===== hdl/fms_in_stage.sv =====
module fms_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fms_pkg::in_item_t  in_data_i,
  input  logic               take_i,
  output fms_pkg::stage_hs_t hs_o,
  output fms_pkg::in_item_t  item_o
);

  logic              valid_q;
  fms_pkg::in_item_t item_q;
  logic              load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign hs_o.valid = valid_q;
  assign item_o     = item_q;

endmodule

// ===== hdl/fms_core.sv =====
module fms_core #(
  parameter int unsigned DEBOUNCE_TICKS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [fms_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fms_pkg::DelayW-1:0]    cfg_data_i,
  input  fms_pkg::stage_hs_t            hs_i,
  input  fms_pkg::in_item_t             item_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fms_pkg::out_item_t            out_data_o
);

  localparam int unsigned CntW = $clog2(DEBOUNCE_TICKS + 1);
  localparam logic [CntW-1:0] DebMax = CntW'(DEBOUNCE_TICKS);

  logic [fms_pkg::DelayW-1:0] grip_q, settle_q;

  fms_pkg::phase_e            phase_q, phase_d;
  fms_pkg::event_e            pending_q, pending_d;
  logic [fms_pkg::TimeW-1:0]  entry_q, entry_d;
  logic                       first_q, first_d;
  logic [CntW-1:0]            cnt_q, cnt_d;

  logic                       out_valid_q;
  fms_pkg::out_item_t         out_q, res;

  logic                       can_load;
  logic [CntW-1:0]            cnt_inc;
  logic                       stable;
  logic [fms_pkg::TimeW-1:0]  delta;
  logic                       grip_due, settle_due;

  assign can_load = !out_valid_q || !out_stall_i;
  assign take_o   = hs_i.valid && can_load;

  assign cnt_inc    = (cnt_q < DebMax) ? cnt_q + 1'b1 : cnt_q;
  assign stable     = item_i.raw_arrived && (cnt_inc == DebMax);
  assign delta      = item_i.now_ms - entry_q;
  assign grip_due   = delta >= {{(fms_pkg::TimeW - fms_pkg::DelayW){1'b0}}, grip_q};
  assign settle_due = delta >= {{(fms_pkg::TimeW - fms_pkg::DelayW){1'b0}}, settle_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grip_q   <= fms_pkg::GripDelayRst;
      settle_q <= fms_pkg::SettleDelayRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fms_pkg::CFG_GRIP_DELAY:   grip_q   <= cfg_data_i;
        fms_pkg::CFG_SETTLE_DELAY: settle_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    entry_d   = entry_q;
    first_d   = first_q;
    cnt_d     = cnt_q;
    unique case (item_i.req_type)
      fms_pkg::REQ_TICK: begin
        cnt_d = item_i.raw_arrived ? cnt_inc : '0;
        unique case (phase_q)
          fms_pkg::PH_HOME: begin
            if (first_q) begin
              first_d = 1'b0;
              entry_d = item_i.now_ms;
            end
            if (stable) begin
              pending_d = fms_pkg::EV_HOME;
              phase_d   = fms_pkg::PH_GRIP;
              entry_d   = item_i.now_ms;
              first_d   = 1'b1;
              cnt_d     = '0;
            end
          end
          fms_pkg::PH_GRIP: begin
            if (grip_due) begin
              phase_d = fms_pkg::PH_ROTATE;
              entry_d = item_i.now_ms;
            end
          end
          fms_pkg::PH_ROTATE: begin
            if (stable) begin
              pending_d = fms_pkg::EV_ROTATE;
              phase_d   = fms_pkg::PH_SETTLE;
              entry_d   = item_i.now_ms;
              first_d   = 1'b1;
              cnt_d     = '0;
            end
          end
          fms_pkg::PH_SETTLE: begin
            if (settle_due) begin
              pending_d = fms_pkg::EV_FINISHED;
              phase_d   = fms_pkg::PH_DONE;
              entry_d   = item_i.now_ms;
            end
          end
          default: ;
        endcase
      end
      fms_pkg::REQ_START: begin
        if (phase_q == fms_pkg::PH_IDLE || phase_q == fms_pkg::PH_DONE) begin
          phase_d = fms_pkg::PH_HOME;
          entry_d = '0;
          first_d = 1'b1;
          cnt_d   = '0;
        end
      end
      fms_pkg::REQ_RESET: begin
        phase_d   = fms_pkg::PH_IDLE;
        pending_d = fms_pkg::EV_NONE;
        entry_d   = '0;
        first_d   = 1'b1;
        cnt_d     = '0;
      end
      default: begin
        pending_d = fms_pkg::EV_NONE;
      end
    endcase
  end

  always_comb begin
    res              = '0;
    res.phase_now    = phase_d;
    res.is_done      = (phase_d == fms_pkg::PH_DONE);
    unique case (item_i.req_type)
      fms_pkg::REQ_TICK: begin
        unique case (phase_q)
          fms_pkg::PH_HOME: begin
            if (first_q) begin
              res.target_cmd = fms_pkg::TGT_HOME;
            end
            if (stable) begin
              res.valve_cmd = fms_pkg::VLV_HOLD;
            end
          end
          fms_pkg::PH_GRIP: begin
            if (grip_due) begin
              res.target_cmd = fms_pkg::TGT_HALF;
            end
          end
          fms_pkg::PH_SETTLE: begin
            if (settle_due) begin
              res.valve_cmd = fms_pkg::VLV_RELEASE;
            end
          end
          default: ;
        endcase
      end
      fms_pkg::REQ_START: ;
      fms_pkg::REQ_RESET: begin
        res.motor_stop = 1'b1;
        res.valve_cmd  = fms_pkg::VLV_RELEASE;
      end
      default: begin
        res.popped_event = pending_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= fms_pkg::PH_IDLE;
      pending_q   <= fms_pkg::EV_NONE;
      entry_q     <= '0;
      first_q     <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      phase_q     <= phase_d;
      pending_q   <= pending_d;
      entry_q     <= entry_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/flip_motion_sequencer_top.sv =====
// A request is captured in the input register, and its result in the result register.
// Throughput: one request per cycle while results drain. A stalled result
// holds the result register; the input register, if empty, takes one more request
// and then raises stall until the result is accepted.
// Reset (rst_ni low, asynchronous): phase idle, no pending event, debounce
// count zero, delays back to 250 ms and 200 ms, both stages empty.
module flip_motion_sequencer_top #(
  parameter int unsigned DEBOUNCE_TICKS = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fms_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fms_pkg::out_item_t          out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [fms_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [fms_pkg::DelayW-1:0]  cfg_data_i
);

  fms_pkg::stage_hs_t hs;
  fms_pkg::in_item_t  item;
  logic               take;

  assign cfg_ready_o = 1'b1;

  fms_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .hs_o       (hs),
    .item_o     (item)
  );

  fms_core #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .hs_i        (hs),
    .item_i      (item),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/fms_checker.sv =====
module fms_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input fms_pkg::out_item_t          out_data_o
);

  a_done_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_done == (out_data_o.phase_now == fms_pkg::PH_DONE)))
    else $error("is_done disagrees with phase");

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.motor_stop |->
      out_data_o.phase_now == fms_pkg::PH_IDLE &&
      out_data_o.valve_cmd == fms_pkg::VLV_RELEASE &&
      out_data_o.target_cmd == fms_pkg::TGT_NONE)
    else $error("motor stop without idle phase and release");

  a_half_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.target_cmd == fms_pkg::TGT_HALF |->
      out_data_o.phase_now == fms_pkg::PH_ROTATE)
    else $error("half-turn target outside rotating phase");

  a_pop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.popped_event != fms_pkg::EV_NONE |->
      !out_data_o.motor_stop && out_data_o.target_cmd == fms_pkg::TGT_NONE &&
      out_data_o.valve_cmd == fms_pkg::VLV_NONE)
    else $error("popped event alongside a command");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind flip_motion_sequencer_top fms_checker u_fms_checker (.*);
